// ===== rtl/core/pbwa_pkg.sv =====
// Shared types and constants of the PCI BAR window allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pbwa_pkg;

   localparam int unsigned ADDR_W     = 64;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;

   // Request kinds.
   localparam logic [1:0] REQ_INIT  = 2'd0;
   localparam logic [1:0] REQ_BAR   = 2'd1;
   localparam logic [1:0] REQ_ROM   = 2'd2;
   localparam logic [1:0] REQ_ALIGN = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_NOROOM = 2'd2;
   localparam logic [1:0] ST_HIGH   = 2'd3;

   // Window codes.
   localparam logic [1:0] WIN_IO   = 2'd0;
   localparam logic [1:0] WIN_MEM  = 2'd1;
   localparam logic [1:0] WIN_PREF = 2'd2;
   localparam logic [1:0] WIN_NONE = 2'd3;

   // Register indexes (byte address is eight times the index).
   localparam logic [2:0] CSR_IO_START    = 3'd0;
   localparam logic [2:0] CSR_IO_SIZE     = 3'd1;
   localparam logic [2:0] CSR_MEM_START   = 3'd2;
   localparam logic [2:0] CSR_MEM_SIZE    = 3'd3;
   localparam logic [2:0] CSR_PREF_START  = 3'd4;
   localparam logic [2:0] CSR_PREF_SIZE   = 3'd5;
   localparam logic [2:0] CSR_BRIDGE_LOG2 = 3'd6;

   localparam logic [4:0]        BRIDGE_LOG2_RESET = 5'd20;
   localparam logic [ADDR_W-1:0] ADDR_FLOOR        = 64'h0000_0000_0000_1000;
   localparam logic [ADDR_W-1:0] ALL_ONES          = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0]       WORD_ONES         = 32'hFFFF_FFFF;
   localparam logic [31:0]       IO_SIZE_MASK      = 32'hFFFF_FFFC;
   localparam logic [31:0]       MEM_SIZE_MASK     = 32'hFFFF_FFF0;
   localparam logic [31:0]       ROM_SIZE_MASK     = 32'hFFFF_FFFE;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] response_low;
      logic [31:0] response_high;
      logic [1:0]  window_select;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
      logic [1:0]        window_used;
      logic              is_64bit;
      logic [ADDR_W-1:0] region_size;
      logic              enable_io;
      logic              enable_mem;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] io_window_start;
      logic [ADDR_W-1:0] io_window_size;
      logic [ADDR_W-1:0] mem_window_start;
      logic [ADDR_W-1:0] mem_window_size;
      logic [ADDR_W-1:0] pref_window_start;
      logic [ADDR_W-1:0] pref_window_size;
      logic [4:0]        bridge_align_log2;
   } cfg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ROUND,
      S_ALIGN,
      S_OFFSET,
      S_ROOM,
      S_FIT,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic round;
      logic align;
      logic offset;
      logic room;
      logic fit;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic early_done;
      logic align_only;
   } dp_stat_type;

endpackage

// ===== rtl/core/pbwa_ctrl.sv =====
// Sequencer of the PCI BAR window allocator: steps one request through the datapath.
// Depends on pbwa_pkg for the state, command and status types.
module pbwa_ctrl
   import pbwa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The result register can take a new beat when empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = dp_stat.early_done ? S_FINISH : S_ROUND;
         end
         S_ROUND:  state_in = S_ALIGN;
         S_ALIGN: begin
            state_in = dp_stat.align_only ? S_FINISH : S_OFFSET;
         end
         S_OFFSET: state_in = S_ROOM;
         S_ROOM:   state_in = S_FIT;
         S_FIT:    state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      dp_cmd.load   = (state_ff == S_IDLE) && req_valid;
      dp_cmd.decode = (state_ff == S_DECODE);
      dp_cmd.round  = (state_ff == S_ROUND);
      dp_cmd.align  = (state_ff == S_ALIGN);
      dp_cmd.offset = (state_ff == S_OFFSET);
      dp_cmd.room   = (state_ff == S_ROOM);
      dp_cmd.fit    = (state_ff == S_FIT);
      dp_cmd.finish = (state_ff == S_FINISH) && out_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (dp_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/pbwa_dp.sv =====
// Datapath of the PCI BAR window allocator: decode, cursors, align and room checks.
// Depends on pbwa_pkg; driven step by step by pbwa_ctrl.
module pbwa_dp
   import pbwa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  dp_cmd_type   dp_cmd,
   input  req_item_type req_payload,
   output dp_stat_type  dp_stat,
   output rsp_item_type rsp_payload
);

   req_item_type      req_ff;
   logic [ADDR_W-1:0] io_cursor_ff, mem_cursor_ff, pref_cursor_ff;

   logic [ADDR_W-1:0] size_ff, cur_ff, start_ff, wsize_ff;
   logic [1:0]        win_ff, early_status_ff;
   logic              wide_ff, en_io_ff, en_mem_ff, early_ff;

   logic [ADDR_W-1:0] orv_ff, a_ff, off_ff, rem_ff, end_addr_ff;
   logic              wrap_ff, below_ff, over_ff, big_ff, carry_ff;

   rsp_item_type      rsp_ff;

   // Decode signals.
   logic [31:0]       lo, hi;
   logic              d_wide;
   logic [ADDR_W-1:0] d_op, d_neg, d_bar_size, d_bridge_al;
   logic [ADDR_W-1:0] d_size, d_cur, d_start, d_wsize;
   logic [1:0]        d_win, d_status;
   logic              d_en_io, d_en_mem, d_early;

   // Step results.
   logic [ADDR_W:0]   diff_off, diff_rem, sum_end;

   // Finish signals.
   logic [1:0]        f_status;
   logic [ADDR_W-1:0] f_addr, f_cursor;
   logic              f_update;

   assign lo = req_ff.response_low;
   assign hi = req_ff.response_high;

   assign d_wide      = !lo[0] && (lo[2:1] == 2'b10);
   assign d_bridge_al = ADDR_W'(1) << cfg.bridge_align_log2;

   // One negation serves all size decodes; 32-bit sizes keep the low word only.
   always_comb begin
      unique case (req_ff.req_type)
         REQ_BAR: begin
            priority if (lo[0]) begin
               d_op = {32'd0, lo & IO_SIZE_MASK};
            end else if (d_wide) begin
               d_op = {hi, lo & MEM_SIZE_MASK};
            end else begin
               d_op = {32'd0, lo & MEM_SIZE_MASK};
            end
         end
         REQ_ROM: d_op = {32'd0, lo & ROM_SIZE_MASK};
         default: d_op = '0;
      endcase
   end

   assign d_neg      = ADDR_W'(0) - d_op;
   assign d_bar_size = d_wide ? d_neg : {32'd0, d_neg[31:0]};

   always_comb begin
      d_size   = '0;
      d_win    = WIN_IO;
      d_en_io  = 1'b0;
      d_en_mem = 1'b0;
      d_early  = 1'b1;
      d_status = ST_OK;
      unique case (req_ff.req_type)
         REQ_INIT: begin
            d_early = 1'b1;
         end
         REQ_BAR: begin
            if (lo == 32'd0 || lo == WORD_ONES || d_op == '0) begin
               d_status = ST_ABSENT;
            end else begin
               d_size   = d_bar_size;
               d_en_io  = lo[0];
               d_en_mem = !lo[0];
               priority if (lo[0]) begin
                  d_win = WIN_IO;
               end else if (lo[3] && cfg.pref_window_size != '0 &&
                            (d_wide || pref_cursor_ff[63:32] == 32'd0)) begin
                  d_win = WIN_PREF;
               end else begin
                  d_win = WIN_MEM;
               end
            end
         end
         REQ_ROM: begin
            if (d_op == '0) begin
               d_status = ST_ABSENT;
            end else begin
               d_size   = {32'd0, d_neg[31:0]};
               d_win    = WIN_MEM;
               d_en_mem = 1'b1;
            end
         end
         default: begin
            if (req_ff.window_select == WIN_NONE) begin
               d_status = ST_ABSENT;
            end else begin
               d_win  = req_ff.window_select;
               d_size = (req_ff.window_select == WIN_IO) ? ADDR_FLOOR : d_bridge_al;
            end
         end
      endcase

      unique case (d_win)
         WIN_IO: begin
            d_cur   = io_cursor_ff;
            d_start = cfg.io_window_start;
            d_wsize = cfg.io_window_size;
         end
         WIN_MEM: begin
            d_cur   = mem_cursor_ff;
            d_start = cfg.mem_window_start;
            d_wsize = cfg.mem_window_size;
         end
         default: begin
            d_cur   = pref_cursor_ff;
            d_start = cfg.pref_window_start;
            d_wsize = cfg.pref_window_size;
         end
      endcase

      // A selected window of size zero counts as missing.
      if (req_ff.req_type != REQ_INIT && d_status == ST_OK) begin
         if (d_wsize == '0) begin
            d_status = ST_ABSENT;
            if (req_ff.req_type == REQ_ALIGN) begin
               d_win  = WIN_IO;
               d_size = '0;
            end
         end else begin
            d_early = 1'b0;
         end
      end
   end

   assign dp_stat.early_done = d_early;
   assign dp_stat.align_only = (req_ff.req_type == REQ_ALIGN);

   assign diff_off = {1'b0, a_ff} - {1'b0, start_ff};
   assign diff_rem = {1'b0, wsize_ff} - {1'b0, off_ff};
   assign sum_end  = {1'b0, a_ff} + {1'b0, size_ff};

   // Result selection and cursor update.
   always_comb begin
      f_status = ST_OK;
      f_update = 1'b0;
      f_cursor = end_addr_ff;
      priority if (early_ff) begin
         f_status = early_status_ff;
      end else if (req_ff.req_type == REQ_ALIGN) begin
         f_status = wrap_ff ? ST_NOROOM : ST_OK;
         f_cursor = a_ff;
         f_update = !wrap_ff;
      end else begin
         priority if (wrap_ff || below_ff || over_ff || big_ff || carry_ff) begin
            f_status = ST_NOROOM;
         end else if (a_ff[63:32] != 32'd0 && !wide_ff) begin
            f_status = ST_HIGH;
         end else begin
            f_status = ST_OK;
            f_update = 1'b1;
         end
      end
      priority if (f_status != ST_OK) begin
         f_addr = ALL_ONES;
      end else if (early_ff) begin
         f_addr = '0;
      end else begin
         f_addr = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) req_ff <= req_payload;
      if (dp_cmd.decode) begin
         size_ff         <= d_size;
         win_ff          <= d_win;
         // A present BAR keeps its width even when its window is missing.
         wide_ff         <= (req_ff.req_type == REQ_BAR) &&
                            !(lo == 32'd0 || lo == WORD_ONES || d_op == '0) && d_wide;
         en_io_ff        <= d_en_io;
         en_mem_ff       <= d_en_mem;
         early_ff        <= d_early;
         early_status_ff <= d_status;
         cur_ff          <= d_cur;
         start_ff        <= d_start;
         wsize_ff        <= d_wsize;
      end
      if (dp_cmd.round) orv_ff <= (cur_ff - ADDR_W'(1)) | (size_ff - ADDR_W'(1));
      if (dp_cmd.align) begin
         a_ff    <= orv_ff + ADDR_W'(1);
         wrap_ff <= (cur_ff != '0) && (orv_ff == ALL_ONES);
      end
      if (dp_cmd.offset) begin
         off_ff   <= diff_off[ADDR_W-1:0];
         below_ff <= diff_off[ADDR_W];
      end
      if (dp_cmd.room) begin
         rem_ff  <= diff_rem[ADDR_W-1:0];
         over_ff <= diff_rem[ADDR_W];
      end
      if (dp_cmd.fit) begin
         big_ff      <= size_ff > rem_ff;
         end_addr_ff <= sum_end[ADDR_W-1:0];
         carry_ff    <= sum_end[ADDR_W];
      end
      if (dp_cmd.finish) begin
         rsp_ff.status      <= f_status;
         rsp_ff.address     <= f_addr;
         rsp_ff.window_used <= win_ff;
         rsp_ff.is_64bit    <= wide_ff;
         rsp_ff.region_size <= size_ff;
         rsp_ff.enable_io   <= en_io_ff;
         rsp_ff.enable_mem  <= en_mem_ff;
      end
   end

   // Cursors: init loads every cursor from its window start with a 4 KiB floor.
   always_ff @(posedge clock) begin
      if (reset) begin
         io_cursor_ff   <= '0;
         mem_cursor_ff  <= '0;
         pref_cursor_ff <= '0;
      end else if (dp_cmd.finish) begin
         if (early_ff && req_ff.req_type == REQ_INIT) begin
            io_cursor_ff   <= (cfg.io_window_start < ADDR_FLOOR) ?
                              ADDR_FLOOR : cfg.io_window_start;
            mem_cursor_ff  <= (cfg.mem_window_start < ADDR_FLOOR) ?
                              ADDR_FLOOR : cfg.mem_window_start;
            pref_cursor_ff <= (cfg.pref_window_start < ADDR_FLOOR) ?
                              ADDR_FLOOR : cfg.pref_window_start;
         end else if (f_update) begin
            unique case (win_ff)
               WIN_IO:   io_cursor_ff   <= f_cursor;
               WIN_MEM:  mem_cursor_ff  <= f_cursor;
               WIN_PREF: pref_cursor_ff <= f_cursor;
               default:  ;
            endcase
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/pci_bar_window_allocator_unit.sv =====
// Top level of the PCI BAR window allocator: register file, sequencer and datapath.
// Depends on pbwa_pkg, pbwa_ctrl and pbwa_dp.
// Steps from input beat to result beat: decode and finish for init or an early failure,
// also round and align for an align request, and also offset, room and fit for a BAR or
// ROM allocation, on one shared 64-bit add/compare datapath; new beats wait for idle.
// Reset (synchronous) empties the result register, zeroes all cursors and registers, and
// sets bridge_align_log2 to 20.
module pci_bar_window_allocator_unit
   import pbwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_payload,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_payload,
   // Register port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type     cfg_ff;
   logic        csr_write;
   logic [2:0]  csr_index;
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // The window registers are 64 bits wide, so each register occupies an 8-byte slot.
   // The port never stalls, and a write lands at the edge that ends its access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.io_window_start   <= '0;
         cfg_ff.io_window_size    <= '0;
         cfg_ff.mem_window_start  <= '0;
         cfg_ff.mem_window_size   <= '0;
         cfg_ff.pref_window_start <= '0;
         cfg_ff.pref_window_size  <= '0;
         cfg_ff.bridge_align_log2 <= BRIDGE_LOG2_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IO_START:    cfg_ff.io_window_start   <= pwdata;
            CSR_IO_SIZE:     cfg_ff.io_window_size    <= pwdata;
            CSR_MEM_START:   cfg_ff.mem_window_start  <= pwdata;
            CSR_MEM_SIZE:    cfg_ff.mem_window_size   <= pwdata;
            CSR_PREF_START:  cfg_ff.pref_window_start <= pwdata;
            CSR_PREF_SIZE:   cfg_ff.pref_window_size  <= pwdata;
            CSR_BRIDGE_LOG2: cfg_ff.bridge_align_log2 <= pwdata[4:0];
            default:         ;
         endcase
      end
   end

   // Reads return the stored value; the unused slot reads as zero.
   always_comb begin
      unique case (csr_index)
         CSR_IO_START:    prdata = cfg_ff.io_window_start;
         CSR_IO_SIZE:     prdata = cfg_ff.io_window_size;
         CSR_MEM_START:   prdata = cfg_ff.mem_window_start;
         CSR_MEM_SIZE:    prdata = cfg_ff.mem_window_size;
         CSR_PREF_START:  prdata = cfg_ff.pref_window_start;
         CSR_PREF_SIZE:   prdata = cfg_ff.pref_window_size;
         CSR_BRIDGE_LOG2: prdata = {59'd0, cfg_ff.bridge_align_log2};
         default:         prdata = '0;
      endcase
   end

   // The sequencer accepts a beat only when idle, then walks the datapath through
   // decode, round, align and the room checks. The finished result sits in an output
   // register, so a new beat is accepted while the previous one waits to be taken.
   pbwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   pbwa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .dp_cmd      (dp_cmd),
      .req_payload (req_payload),
      .dp_stat     (dp_stat),
      .rsp_payload (rsp_payload)
   );

endmodule
